// ===== rtl/islip_crossbar_scheduler_top_defines.svh =====
// ----------------------------------------------------------------------------
// iSLIP scheduler assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ISLIP_CROSSBAR_SCHEDULER_TOP_DEFINES_SVH
`define ISLIP_CROSSBAR_SCHEDULER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ISLIP_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ISLIP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/islip_pkg.sv =====
// ----------------------------------------------------------------------------
// iSLIP scheduler package
// Widths, defaults and types shared by the scheduler's channels and modules.
// ----------------------------------------------------------------------------
`default_nettype none

package islip_pkg;

   // Fixed widths of the matrix fields and the iteration register.
   localparam int MATRIX_WIDTH = 64;
   localparam int COUNT_WIDTH  = 4;

   // Default switch size.
   localparam int DEFAULT_PORTS = 8;

   typedef logic [MATRIX_WIDTH-1:0] matrix_type;
   typedef logic [COUNT_WIDTH-1:0]  count_type;

   // Iterations per slot after reset.
   localparam count_type COUNT_RESET = count_type'(1);

endpackage

`default_nettype wire

// ===== rtl/islip_channels.sv =====
// ----------------------------------------------------------------------------
// iSLIP scheduler channels
// Valid/ready channels for request items, result items and the register write.
// ----------------------------------------------------------------------------
`default_nettype none

// Request item: one request matrix per cell slot.
interface islip_req_if import islip_pkg::*; ();
   logic       valid;
   logic       ready;
   matrix_type request_matrix;

   modport source (output valid, output request_matrix, input ready);
   modport sink   (input valid, input request_matrix, output ready);
endinterface

// Result item: the matching and the requests left over.
interface islip_rsp_if import islip_pkg::*; ();
   logic       valid;
   logic       ready;
   matrix_type match_matrix;
   matrix_type remaining_requests;

   modport source (output valid, output match_matrix, output remaining_requests,
                   input ready);
   modport sink   (input valid, input match_matrix, input remaining_requests,
                   output ready);
endinterface

// Register write: the iteration count.
interface islip_csr_if import islip_pkg::*; ();
   logic      valid;
   logic      ready;
   count_type iteration_count;

   modport source (output valid, output iteration_count, input ready);
   modport sink   (input valid, input iteration_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/islip_rr_arb.sv =====
// ----------------------------------------------------------------------------
// iSLIP round-robin arbiter
// Picks the first set request at or after the pointer, wrapping round.
// ----------------------------------------------------------------------------
`default_nettype none

module islip_rr_arb #(
   parameter int N  = 8,
   parameter int PW = 3
) (
   input  logic [N-1:0]  req_vec,
   input  logic [PW-1:0] ptr,
   output logic [N-1:0]  grant_vec
);

   logic [N-1:0] upper_mask;
   logic [N-1:0] upper_req;
   logic [N-1:0] search_vec;

   // Requests at or above the pointer win first; otherwise wrap to the bottom.
   always_comb begin
      for (int j = 0; j < N; j++) begin
         upper_mask[j] = (ptr <= PW'(j));
      end
      upper_req  = req_vec & upper_mask;
      search_vec = (|upper_req) ? upper_req : req_vec;
      // Isolate the lowest set bit of the chosen vector.
      grant_vec  = search_vec & (~search_vec + N'(1));
   end

endmodule

`default_nettype wire

// ===== rtl/islip_cell.sv =====
// ----------------------------------------------------------------------------
// iSLIP iteration cell
// One request-grant-accept iteration, registered, with a valid/ready link to
// its neighbours. The first cell also moves the pointers it carries.
// ----------------------------------------------------------------------------
`default_nettype none

module islip_cell import islip_pkg::*; #(
   parameter int PORTS = DEFAULT_PORTS,
   parameter int PTR_W = 3,
   parameter int STAGE = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  count_type                         iteration_count,
   input  logic                              up_valid,
   output logic                              up_ready,
   input  logic [PORTS*PORTS-1:0]            up_req,
   input  logic [PORTS*PORTS-1:0]            up_match,
   input  logic [PORTS-1:0][PTR_W-1:0]       up_gptr,
   input  logic [PORTS-1:0][PTR_W-1:0]       up_aptr,
   output logic                              dn_valid,
   input  logic                              dn_ready,
   output logic [PORTS*PORTS-1:0]            dn_req,
   output logic [PORTS*PORTS-1:0]            dn_match,
   output logic [PORTS-1:0][PTR_W-1:0]       dn_gptr,
   output logic [PORTS-1:0][PTR_W-1:0]       dn_aptr
);

   // Step a pointer one place on, wrapping at the port count.
   function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] x);
      if (x == PTR_W'(PORTS - 1)) begin
         return '0;
      end
      return x + 1'b1;
   endfunction

   logic                            active;
   logic                            take;
   logic [PORTS-1:0][PORTS-1:0]     req_mat;   // [input][output]
   logic [PORTS-1:0][PORTS-1:0]     req_col;   // [output][input]
   logic [PORTS-1:0][PORTS-1:0]     gnt_col;   // [output][input]
   logic [PORTS-1:0][PORTS-1:0]     gnt_row;   // [input][output]
   logic [PORTS-1:0][PORTS-1:0]     acc_row;   // [input][output]
   logic [PORTS-1:0][PORTS-1:0]     acc_col;   // [output][input]
   logic [PORTS-1:0]                row_hit;
   logic [PORTS-1:0]                col_hit;
   logic [PORTS-1:0][PTR_W-1:0]     out_idx;   // matched output per input
   logic [PORTS-1:0][PTR_W-1:0]     in_idx;    // matched input per output
   logic [PORTS-1:0][PORTS-1:0]     left_mat;

   logic [PORTS*PORTS-1:0]          req_in;
   logic [PORTS*PORTS-1:0]          match_in;
   logic [PORTS-1:0][PTR_W-1:0]     gptr_in;
   logic [PORTS-1:0][PTR_W-1:0]     aptr_in;
   logic [PORTS*PORTS-1:0]          req_ff;
   logic [PORTS*PORTS-1:0]          match_ff;
   logic [PORTS-1:0][PTR_W-1:0]     gptr_ff;
   logic [PORTS-1:0][PTR_W-1:0]     aptr_ff;
   logic                            valid_ff;

   // This cell runs its iteration only when the count reaches it.
   assign active  = (iteration_count > COUNT_WIDTH'(STAGE));
   assign req_mat = up_req;

   // Column view of the requests for the grant arbiters.
   always_comb begin
      for (int o = 0; o < PORTS; o++) begin
         for (int i = 0; i < PORTS; i++) begin
            req_col[o][i] = req_mat[i][o];
         end
      end
   end

   // Grant phase: one arbiter per output over the requesting inputs.
   for (genvar o = 0; o < PORTS; o++) begin : g_grant
      islip_rr_arb #(.N(PORTS), .PW(PTR_W)) u_grant_arb (
         .req_vec   (req_col[o]),
         .ptr       (up_gptr[o]),
         .grant_vec (gnt_col[o])
      );
   end

   // Row view of the grants for the accept arbiters.
   always_comb begin
      for (int i = 0; i < PORTS; i++) begin
         for (int o = 0; o < PORTS; o++) begin
            gnt_row[i][o] = gnt_col[o][i];
         end
      end
   end

   // Accept phase: one arbiter per input over the grants it received.
   for (genvar i = 0; i < PORTS; i++) begin : g_accept
      islip_rr_arb #(.N(PORTS), .PW(PTR_W)) u_accept_arb (
         .req_vec   (gnt_row[i]),
         .ptr       (up_aptr[i]),
         .grant_vec (acc_row[i])
      );
   end

   // Matched rows and columns, partner indices and the cleared requests.
   always_comb begin
      for (int o = 0; o < PORTS; o++) begin
         for (int i = 0; i < PORTS; i++) begin
            acc_col[o][i] = acc_row[i][o];
         end
      end
      for (int i = 0; i < PORTS; i++) begin
         row_hit[i] = |acc_row[i];
         col_hit[i] = |acc_col[i];
         out_idx[i] = '0;
         in_idx[i]  = '0;
         for (int k = 0; k < PORTS; k++) begin
            if (acc_row[i][k]) begin
               out_idx[i] = out_idx[i] | PTR_W'(k);
            end
            if (acc_col[i][k]) begin
               in_idx[i] = in_idx[i] | PTR_W'(k);
            end
         end
      end
      for (int i = 0; i < PORTS; i++) begin
         for (int o = 0; o < PORTS; o++) begin
            left_mat[i][o] = req_mat[i][o] & ~row_hit[i] & ~col_hit[o];
         end
      end
   end

   // Next values: an idle cell passes its item through untouched.
   always_comb begin
      req_in   = up_req;
      match_in = up_match;
      gptr_in  = up_gptr;
      aptr_in  = up_aptr;
      if (active) begin
         req_in   = left_mat;
         match_in = up_match | acc_row;
         if (STAGE == 0) begin
            for (int k = 0; k < PORTS; k++) begin
               if (col_hit[k]) begin
                  gptr_in[k] = wrap_next(in_idx[k]);
               end
               if (row_hit[k]) begin
                  aptr_in[k] = wrap_next(out_idx[k]);
               end
            end
         end
      end
   end

   // Link handshake: the cell takes an item when empty or emptying.
   assign up_ready = ~valid_ff | dn_ready;
   assign take     = up_valid & up_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         gptr_ff  <= '0;
         aptr_ff  <= '0;
      end else begin
         if (up_ready) begin
            valid_ff <= up_valid;
         end
         if (take) begin
            gptr_ff <= gptr_in;
            aptr_ff <= aptr_in;
         end
      end
   end

   // Matrix payload needs no reset.
   always_ff @(posedge clock) begin
      if (take) begin
         req_ff   <= req_in;
         match_ff <= match_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_req   = req_ff;
   assign dn_match = match_ff;
   assign dn_gptr  = gptr_ff;
   assign dn_aptr  = aptr_ff;

endmodule

`default_nettype wire

// ===== rtl/islip_crossbar_scheduler_top.sv =====
// A taken request item passes the PORTS cell registers in turn to the result.
// Throughput: one request item per cycle while results are taken; each cell runs
// at most one iteration, so the chain length sets the latency and not the rate.
// Reset: synchronous, active high; clears all pointers to zero, empties the
// chain and sets the iteration count to one.
// ----------------------------------------------------------------------------
// iSLIP crossbar scheduler
// A chain of iteration cells computes one iSLIP matching per request matrix.
// The first cell holds the grant and accept pointers and moves them on its
// first-iteration matches; later cells carry the moved pointers alongside.
// ----------------------------------------------------------------------------
`default_nettype none

`include "islip_crossbar_scheduler_top_defines.svh"

module islip_crossbar_scheduler_top import islip_pkg::*; #(
   parameter int PORTS = DEFAULT_PORTS
) (
   input  logic       clock,
   input  logic       reset,
   islip_req_if.sink   req_chan,
   islip_rsp_if.source rsp_chan,
   islip_csr_if.sink   csr_chan
);

   localparam int PTR_W = (PORTS > 1) ? $clog2(PORTS) : 1;
   localparam int USED  = PORTS * PORTS;
   localparam matrix_type USED_MASK = {MATRIX_WIDTH{1'b1}} >> (MATRIX_WIDTH - USED);

   count_type                   count_ff;
   logic [PORTS:0]              vld;
   logic [PORTS:0]              rdy;
   logic [USED-1:0]             req_d   [0:PORTS];
   logic [USED-1:0]             match_d [0:PORTS];
   logic [PORTS-1:0][PTR_W-1:0] gptr_d  [1:PORTS];
   logic [PORTS-1:0][PTR_W-1:0] aptr_d  [1:PORTS];

   // Iteration count register; writes are always taken.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
      end else if (csr_chan.valid) begin
         count_ff <= csr_chan.iteration_count;
      end
   end

   // Head of the chain: unused request bits are dropped here.
   assign vld[0]         = req_chan.valid;
   assign req_chan.ready = rdy[0];
   assign req_d[0]       = req_chan.request_matrix[USED-1:0];
   assign match_d[0]     = '0;

   // Chain of iteration cells; the first one feeds its pointers back to itself.
   for (genvar k = 0; k < PORTS; k++) begin : g_cell
      islip_cell #(.PORTS(PORTS), .PTR_W(PTR_W), .STAGE(k)) u_cell (
         .clock           (clock),
         .reset           (reset),
         .iteration_count (count_ff),
         .up_valid        (vld[k]),
         .up_ready        (rdy[k]),
         .up_req          (req_d[k]),
         .up_match        (match_d[k]),
         .up_gptr         ((k == 0) ? gptr_d[1] : gptr_d[(k == 0) ? 1 : k]),
         .up_aptr         ((k == 0) ? aptr_d[1] : aptr_d[(k == 0) ? 1 : k]),
         .dn_valid        (vld[k+1]),
         .dn_ready        (rdy[k+1]),
         .dn_req          (req_d[k+1]),
         .dn_match        (match_d[k+1]),
         .dn_gptr         (gptr_d[k+1]),
         .dn_aptr         (aptr_d[k+1])
      );
   end

   // Tail of the chain: the last cell's register is the result register.
   assign rsp_chan.valid              = vld[PORTS];
   assign rdy[PORTS]                  = rsp_chan.ready;
   assign rsp_chan.match_matrix       = MATRIX_WIDTH'(match_d[PORTS]);
   assign rsp_chan.remaining_requests = MATRIX_WIDTH'(req_d[PORTS]);

   // A matched pair has its row and column cleared, so nothing overlaps.
   `ISLIP_ASSERT_IMPLIES(a_match_disjoint, rsp_chan.valid, (rsp_chan.match_matrix & rsp_chan.remaining_requests) == '0, "match and remaining requests overlap")

   // Bits beyond the switch size never appear in a result.
   `ISLIP_ASSERT_IMPLIES(a_unused_clear, rsp_chan.valid, ((rsp_chan.match_matrix | rsp_chan.remaining_requests) & ~USED_MASK) == '0, "result sets an unused bit")

   // Pointers move only when a request item enters the chain.
   `ISLIP_ASSERT_NEXT(a_ptr_hold, !(req_chan.valid && req_chan.ready), $stable(gptr_d[1]) && $stable(aptr_d[1]), "pointers moved without a new item")

   // Every pointer stays below the port count, at the head and the tail.
   for (genvar p = 0; p < PORTS; p++) begin : g_ptr_chk
      `ISLIP_ASSERT_IMPLIES(a_ptr_range, 1'b1, (gptr_d[1][p] <= PTR_W'(PORTS - 1)) && (aptr_d[1][p] <= PTR_W'(PORTS - 1)) && (gptr_d[PORTS][p] <= PTR_W'(PORTS - 1)) && (aptr_d[PORTS][p] <= PTR_W'(PORTS - 1)), "pointer out of range")
   end

endmodule

`default_nettype wire
